### sv/bchd_pkg.sv
// shared types and constants of the button click-and-hold detector
// no dependencies; used by the top level and its port checker

package bchd_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_LEVEL = 2'd0,
    REG_CLICK_WINDOW   = 2'd1,
    REG_LONG_HOLD      = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam level_t RST_DEBOUNCE_LEVEL = level_t'(3);
  localparam tick_t  RST_CLICK_WINDOW   = tick_t'(8000000);
  localparam tick_t  RST_LONG_HOLD      = tick_t'(80000000);

  // click count codes
  localparam count_t CLICK_MARK_LONG = count_t'(8'hFF);
  localparam count_t CLICK_SAT       = count_t'(254);
  localparam level_t DEBOUNCE_FLOOR  = level_t'(1);

endpackage

### sv/button_click_and_hold_detector.sv
// button click-and-hold detector: debounce, multi-click count and long press
// depends on bchd_pkg

// Each input word is one poll of the button (level and free-running tick
// time) and produces exactly one result word. A poll is captured in an input
// register, evaluated by a single pass of short logic against the gesture
// state, and the result is captured in an output register while the state
// updates in the same cycle, so a new poll is accepted every clock unless
// out_ready stalls: the result is registered behind the input register,
// and the sustained rate is one poll per cycle without stalls. The longest
// path is the one 32-bit elapsed-time subtract and its two compares against
// the click window and the hold time. The input register frees up whenever
// its poll moves on, so one poll is taken while a finished result still
// waits on out_ready. The configuration port is always ready; registers are
// meant to be written only while the block is idle. Time differences are
// taken modulo 2^32, so the tick counter may wrap.

module button_click_and_hold_detector (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // poll input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                button_down,
  input  logic [bchd_pkg::TICK_W-1:0]         now_ticks,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                press_accepted,
  output logic                                first_press,
  output logic                                long_press,
  output logic                                gesture_done,
  output logic [bchd_pkg::COUNT_W-1:0]        click_count,
  output logic                                busy_res
);

  // configuration registers
  bchd_pkg::level_t debounce_level;
  bchd_pkg::tick_t  click_window_ticks;
  bchd_pkg::tick_t  long_hold_ticks;

  // gesture state
  bchd_pkg::level_t debounce_count;
  bchd_pkg::count_t clicks;
  logic             is_pressed;
  logic             is_released;
  logic             is_holding;
  bchd_pkg::tick_t  press_stamp;

  // input register
  logic             in_full;
  logic             in_down;
  bchd_pkg::tick_t  in_now;

  // next values
  bchd_pkg::level_t debounce_count_next;
  bchd_pkg::count_t clicks_next;
  logic             is_pressed_next;
  logic             is_released_next;
  logic             is_holding_next;
  bchd_pkg::tick_t  press_stamp_next;

  logic             accepted;
  logic             first;
  logic             long_hit;
  logic             done;
  bchd_pkg::count_t report;
  logic             busy;

  bchd_pkg::tick_t  elapsed;
  logic             past_window;
  logic             past_hold;
  bchd_pkg::level_t count_up;
  bchd_pkg::level_t count_dn;
  bchd_pkg::count_t clicks_mid;
  logic             advance;

  // the poll moves on when the result register is empty or being drained
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  // one subtract serves both windows
  assign elapsed     = in_now - press_stamp;
  assign past_window = elapsed > click_window_ticks;
  assign past_hold   = elapsed > long_hold_ticks;
  assign count_up    = debounce_count + bchd_pkg::level_t'(1);
  assign count_dn    = debounce_count - bchd_pkg::level_t'(1);

  always_comb begin
    debounce_count_next = debounce_count;
    clicks_mid          = clicks;
    is_pressed_next     = is_pressed;
    is_released_next    = is_released;
    is_holding_next     = is_holding;
    press_stamp_next    = press_stamp;
    accepted            = 1'b0;
    first               = 1'b0;
    long_hit            = 1'b0;
    done                = 1'b0;
    report              = '0;

    if (in_down) begin
      // hold tracking: arm on the first poll past the window, fire later
      if (is_pressed && (clicks != bchd_pkg::CLICK_MARK_LONG) && past_window) begin
        if (!is_holding) begin
          is_holding_next = 1'b1;
        end else if (past_hold) begin
          clicks_mid = bchd_pkg::CLICK_MARK_LONG;
          long_hit   = 1'b1;
        end
      end
      // debounce up toward the level, counter wraps as an 8-bit value
      if (debounce_count != debounce_level) begin
        debounce_count_next = count_up;
        if (count_up == debounce_level) begin
          accepted = 1'b1;
          if (clicks_mid == '0) begin
            clicks_mid      = bchd_pkg::count_t'(1);
            is_pressed_next = 1'b1;
            first           = 1'b1;
          end else if (is_pressed && !past_window) begin
            if (clicks_mid < bchd_pkg::CLICK_SAT) begin
              clicks_mid = clicks_mid + bchd_pkg::count_t'(1);
            end
          end
          press_stamp_next = in_now;
        end
      end
    end else if (debounce_count != bchd_pkg::DEBOUNCE_FLOOR) begin
      debounce_count_next = count_dn;
      if ((count_dn == bchd_pkg::DEBOUNCE_FLOOR) && is_pressed) begin
        is_released_next = 1'b1;
      end
    end

    clicks_next = clicks_mid;

    // gesture end: a fresh stamp this poll means no time has elapsed
    if (is_released_next && is_pressed_next && !accepted && past_window) begin
      done             = 1'b1;
      report           = clicks_mid;
      clicks_next      = '0;
      is_pressed_next  = 1'b0;
      is_released_next = 1'b0;
      is_holding_next  = 1'b0;
    end

    busy = ((debounce_count_next != bchd_pkg::DEBOUNCE_FLOOR) &&
            (debounce_count_next != debounce_level)) ||
           (clicks_next != '0) || is_pressed_next;
  end

  // control state, configuration and gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full            <= 1'b0;
      out_valid          <= 1'b0;
      debounce_level     <= bchd_pkg::RST_DEBOUNCE_LEVEL;
      click_window_ticks <= bchd_pkg::RST_CLICK_WINDOW;
      long_hold_ticks    <= bchd_pkg::RST_LONG_HOLD;
      debounce_count     <= bchd_pkg::DEBOUNCE_FLOOR;
      clicks             <= '0;
      is_pressed         <= 1'b0;
      is_released        <= 1'b0;
      is_holding         <= 1'b0;
      press_stamp        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bchd_pkg::REG_DEBOUNCE_LEVEL: debounce_level <= cfg_data[bchd_pkg::LEVEL_W-1:0];
          bchd_pkg::REG_CLICK_WINDOW:   click_window_ticks <= cfg_data;
          bchd_pkg::REG_LONG_HOLD:      long_hold_ticks <= cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        debounce_count <= debounce_count_next;
        clicks         <= clicks_next;
        is_pressed     <= is_pressed_next;
        is_released    <= is_released_next;
        is_holding     <= is_holding_next;
        press_stamp    <= press_stamp_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_down <= button_down;
      in_now  <= now_ticks;
    end
    if (advance) begin
      press_accepted <= accepted;
      first_press    <= first;
      long_press     <= long_hit;
      gesture_done   <= done;
      click_count    <= report;
      busy_res       <= busy;
    end
  end

endmodule

### sv/bchd_port_check.sv
// port-level checks for the button click-and-hold detector, with bind
// depends on bchd_pkg and button_click_and_hold_detector

module bchd_port_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         press_accepted,
  input logic                         first_press,
  input logic                         gesture_done,
  input logic [bchd_pkg::COUNT_W-1:0] click_count
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a new gesture only opens on an accepted press
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && first_press) |-> press_accepted)
    else $error("first press without accepted press");

  // the count field is only filled when a gesture ends, and then is nonzero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((click_count != '0) == gesture_done))
    else $error("click count disagrees with gesture end");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(click_count) &&
                                   $stable(gesture_done)))
    else $error("stalled result changed");

endmodule

bind button_click_and_hold_detector bchd_port_check u_bchd_port_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .press_accepted (press_accepted),
  .first_press    (first_press),
  .gesture_done   (gesture_done),
  .click_count    (click_count)
);
